@@ src/bdrp_pkg.sv @@
// Shared types and character codes for the bracketed decimal record parser.
package bdrp_pkg;

    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_COMMA        = 8'h2C;
    localparam logic [7:0] CH_DIGIT_LOW    = 8'd48;
    localparam logic [7:0] CH_DIGIT_HIGH   = 8'd57;
    localparam logic [7:0] CODE_BRAKE      = 8'h35;
    localparam logic [7:0] CODE_SPEED      = 8'h37;

    localparam int VALUE_W = 16;

    typedef enum logic [7:0] {
        PH_FIRST  = 8'b0000_0001,
        PH_SECOND = 8'b0000_0010,
        PH_TYPE   = 8'b0000_0100,
        PH_POWER  = 8'b0000_1000,
        PH_GAP    = 8'b0001_0000,
        PH_MARK   = 8'b0010_0000,
        PH_SPEED  = 8'b0100_0000,
        PH_IDLE   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] power_value;
        logic [VALUE_W-1:0] speed_value;
    } out_item_t;

    typedef struct packed {
        phase_t             phase;
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] power;
        logic [VALUE_W-1:0] speed;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        phase: PH_FIRST,
        acc:   '0,
        power: '0,
        speed: '0
    };

endpackage

@@ src/bdrp_step.sv @@
// Next-state logic of the parser for one message byte.
module bdrp_step (
    input  bdrp_pkg::parse_state_t state,
    input  logic [7:0]             data_byte,
    output bdrp_pkg::parse_state_t state_next
);
    import bdrp_pkg::*;

    logic               is_digit;
    logic [VALUE_W-1:0] digit_val;
    logic [VALUE_W-1:0] acc_times_ten;
    logic [VALUE_W-1:0] acc_collect;

    always_comb
    begin
        is_digit      = data_byte inside {[CH_DIGIT_LOW:CH_DIGIT_HIGH]};
        digit_val     = VALUE_W'(data_byte - CH_DIGIT_LOW);
        acc_times_ten = (state.acc << 3) + (state.acc << 1);
        if (data_byte == CH_COMMA)
        begin
            acc_collect = '0;
        end
        else if (is_digit)
        begin
            acc_collect = acc_times_ten + digit_val;
        end
        else
        begin
            acc_collect = state.acc;
        end
    end

    always_comb
    begin
        state_next = state;
        case (state.phase)
            PH_FIRST:
            begin
                state_next.phase = (data_byte == CH_OPEN_CURLY) ? PH_SECOND : PH_IDLE;
            end
            PH_SECOND:
            begin
                state_next.phase = (data_byte == CH_OPEN_SQUARE) ? PH_TYPE : PH_IDLE;
            end
            PH_TYPE:
            begin
                state_next.acc   = '0;
                state_next.phase = (data_byte == CODE_BRAKE) ? PH_POWER : PH_IDLE;
            end
            PH_POWER:
            begin
                if (data_byte == CH_CLOSE_SQUARE)
                begin
                    state_next.power = state.acc;
                    state_next.acc   = '0;
                    state_next.phase = PH_GAP;
                end
                else
                begin
                    state_next.acc = acc_collect;
                end
            end
            PH_GAP:
            begin
                state_next.phase = PH_MARK;
            end
            PH_MARK:
            begin
                state_next.acc   = '0;
                state_next.phase = (data_byte == CODE_SPEED) ? PH_SPEED : PH_IDLE;
            end
            PH_SPEED:
            begin
                if (data_byte == CH_CLOSE_SQUARE)
                begin
                    state_next.speed = state.acc;
                    state_next.phase = PH_IDLE;
                end
                else
                begin
                    state_next.acc = acc_collect;
                end
            end
            default:
            begin
                state_next.phase = PH_IDLE;
            end
        endcase
    end

endmodule

@@ src/bracketed_decimal_record_parser.sv @@
// Top level of the bracketed decimal record parser.
// The parser takes one message byte per cycle while no last byte waits on the
// result side: each accepted item lands in an input register, compare and
// multiply-by-ten logic updates the parse state, and on the byte flagged last
// the power and speed values go to a result register. Back pressure on the
// result side stalls the input register while it holds a last byte, and the
// input side keeps taking items as long as that register can drain.
module bracketed_decimal_record_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bdrp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bdrp_pkg::out_item_t out_data
);
    import bdrp_pkg::*;

    logic         in_valid_reg;
    in_item_t     in_reg;
    logic         out_valid_reg;
    out_item_t    out_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         proc_fire;
    logic         out_free;

    bdrp_step u_step (
        .state      (state_reg),
        .data_byte  (in_reg.data_byte),
        .state_next (state_next)
    );

    // The result register frees up in the same cycle its item is taken.
    assign out_free  = !out_valid_reg || out_ready;
    assign proc_fire = in_valid_reg && (!in_reg.last_byte || out_free);
    assign in_ready  = !in_valid_reg || proc_fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_RESET;
        end
        else if (proc_fire)
        begin
            state_reg <= in_reg.last_byte ? PARSE_RESET : state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && in_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_reg.last_byte)
        begin
            out_reg.power_value <= state_next.power;
            out_reg.speed_value <= state_next.speed;
        end
    end

`ifndef SYNTH
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire && in_reg.last_byte))
        else $error("result appeared without a processed last byte");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_reg.last_byte) |=> (state_reg.phase == PH_FIRST))
        else $error("parser did not restart after the last byte");

    a_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_FIRST) |->
            (state_reg.acc == '0 && state_reg.power == '0 && state_reg.speed == '0))
        else $error("parse state not cleared at message start");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(proc_fire && in_reg.last_byte))
        else $error("pending result overwritten");
`endif

endmodule

@@ verif/bracketed_decimal_record_parser_tb.sv @@
// Self-checking testbench for the bracketed decimal record parser.
module bracketed_decimal_record_parser_tb;
    import bdrp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 150;
    localparam int DIRECTED_N   = 25;

    typedef struct packed {
        logic [7:0]         data;
        logic               last;
        logic               typed;
        logic [VALUE_W-1:0] power;
        logic [VALUE_W-1:0] speed;
    } row_t;

    // Hand-written messages: header mismatches, a full power and speed record,
    // a comma right before the bracket, and a message cut off after two bytes.
    localparam row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{8'h00,           1'b1, 1'b1, 16'd0, 16'd0},
        '{8'hFF,           1'b1, 1'b1, 16'd0, 16'd0},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, 16'd0, 16'd0},
        '{"4",             1'b1, 1'b1, 16'd0, 16'd0},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, 16'd0, 16'd0},
        '{CODE_BRAKE,      1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_COMMA,        1'b0, 1'b0, 16'd0, 16'd0},
        '{"1",             1'b0, 1'b0, 16'd0, 16'd0},
        '{"2",             1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_CLOSE_SQUARE, 1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_COMMA,        1'b0, 1'b0, 16'd0, 16'd0},
        '{CODE_SPEED,      1'b0, 1'b0, 16'd0, 16'd0},
        '{"3",             1'b0, 1'b0, 16'd0, 16'd0},
        '{"4",             1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_CLOSE_SQUARE, 1'b0, 1'b0, 16'd0, 16'd0},
        '{"}",             1'b1, 1'b0, 16'd0, 16'd0},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, 16'd0, 16'd0},
        '{CODE_BRAKE,      1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_COMMA,        1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_CLOSE_SQUARE, 1'b1, 1'b1, 16'd0, 16'd0},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, 16'd0, 16'd0},
        '{CH_OPEN_SQUARE,  1'b1, 1'b1, 16'd0, 16'd0}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    phase_t             msg_phase;
    logic [VALUE_W-1:0] msg_acc;
    logic [VALUE_W-1:0] msg_power;
    logic [VALUE_W-1:0] msg_speed;

    out_item_t  pending_readings[$];
    logic [7:0] msg_bytes[$];
    int         fail_count;
    int         items_sent;
    int         stall_cycles;
    int         src_idle_pct;
    int         sink_idle_pct;
    int         hold_left;
    bit         hold_request;

    bracketed_decimal_record_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void clear_message();
        msg_phase = PH_FIRST;
        msg_acc   = '0;
        msg_power = '0;
        msg_speed = '0;
    endfunction

    // Commas restart the number and other non-digits are skipped.
    function automatic logic [VALUE_W-1:0] add_digit(logic [VALUE_W-1:0] acc, logic [7:0] b);
        logic [VALUE_W-1:0] r;
        r = acc;
        if (b == CH_COMMA)
            r = '0;
        else if (b >= CH_DIGIT_LOW && b <= CH_DIGIT_HIGH)
            r = acc * 16'd10 + {8'd0, b - CH_DIGIT_LOW};
        return r;
    endfunction

    // Advances the parse by one byte; returns 1 with the reading on the last byte.
    function automatic bit parse_byte(input in_item_t it, output out_item_t reading);
        logic [7:0] b;
        b = it.data_byte;
        reading = '0;
        case (msg_phase)
            PH_FIRST:
                if (b == CH_OPEN_CURLY) msg_phase = PH_SECOND;
                else msg_phase = PH_IDLE;
            PH_SECOND:
                if (b == CH_OPEN_SQUARE) msg_phase = PH_TYPE;
                else msg_phase = PH_IDLE;
            PH_TYPE:
            begin
                msg_acc = '0;
                if (b == CODE_BRAKE) msg_phase = PH_POWER;
                else msg_phase = PH_IDLE;
            end
            PH_POWER:
                if (b == CH_CLOSE_SQUARE)
                begin
                    msg_power = msg_acc;
                    msg_acc   = '0;
                    msg_phase = PH_GAP;
                end
                else
                begin
                    msg_acc = add_digit(msg_acc, b);
                end
            PH_GAP:
                msg_phase = PH_MARK;
            PH_MARK:
            begin
                msg_acc = '0;
                if (b == CODE_SPEED) msg_phase = PH_SPEED;
                else msg_phase = PH_IDLE;
            end
            PH_SPEED:
                if (b == CH_CLOSE_SQUARE)
                begin
                    msg_speed = msg_acc;
                    msg_phase = PH_IDLE;
                end
                else
                begin
                    msg_acc = add_digit(msg_acc, b);
                end
            default:
                msg_phase = PH_IDLE;
        endcase
        if (!it.last_byte)
            return 1'b0;
        reading.power_value = msg_power;
        reading.speed_value = msg_speed;
        clear_message();
        return 1'b1;
    endfunction

    // Offers one item, holds it until accepted, then records what it should produce.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_reading);
        out_item_t reading;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (parse_byte(it, reading))
            pending_readings.push_back(typed ? typed_reading : reading);
    endtask

    function automatic logic [7:0] stray_byte();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if (r == CH_CLOSE_SQUARE)
            r = 8'h20;
        return r;
    endfunction

    // Appends a few comma-separated digit groups with the odd stray byte.
    task automatic add_field();
        int groups;
        int n_digits;
        groups = $urandom_range(0, 3);
        for (int g = 0; g < groups; g++)
        begin
            if ($urandom_range(0, 3) != 0)
                msg_bytes.push_back(CH_COMMA);
            n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
            for (int d = 0; d < n_digits; d++)
            begin
                if ($urandom_range(0, 7) == 0)
                    msg_bytes.push_back(stray_byte());
                else
                    msg_bytes.push_back(CH_DIGIT_LOW + 8'($urandom_range(0, 9)));
            end
        end
    endtask

    // Mostly well-formed brake records; the rest is noise or a broken header.
    task automatic build_message();
        int pick;
        int keep;
        msg_bytes.delete();
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            repeat ($urandom_range(1, 6))
                msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick == 1)
        begin
            msg_bytes.push_back(CH_OPEN_CURLY);
            msg_bytes.push_back($urandom_range(0, 1) ? CH_OPEN_SQUARE : stray_byte());
            msg_bytes.push_back($urandom_range(0, 1) ? CODE_SPEED : stray_byte());
            add_field();
            msg_bytes.push_back(CH_CLOSE_SQUARE);
        end
        else
        begin
            msg_bytes.push_back(CH_OPEN_CURLY);
            msg_bytes.push_back(CH_OPEN_SQUARE);
            msg_bytes.push_back(CODE_BRAKE);
            add_field();
            msg_bytes.push_back(CH_CLOSE_SQUARE);
            msg_bytes.push_back(8'($urandom_range(0, 255)));
            msg_bytes.push_back($urandom_range(0, 4) != 0 ? CODE_SPEED : stray_byte());
            add_field();
            msg_bytes.push_back(CH_CLOSE_SQUARE);
            repeat ($urandom_range(0, 2))
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) == 0)
            begin
                keep = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > keep)
                    void'(msg_bytes.pop_back());
            end
        end
    endtask

    task automatic send_message();
        in_item_t it;
        for (int i = 0; i < msg_bytes.size(); i++)
        begin
            it.data_byte = msg_bytes[i];
            it.last_byte = (i == msg_bytes.size() - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, plus a long hold-off when asked for.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected reading: power_value %0d, speed_value %0d",
                       out_data.power_value, out_data.speed_value);
                fail_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (out_data.power_value !== want.power_value)
                begin
                    $error("power_value: expected %0d, actual %0d",
                           want.power_value, out_data.power_value);
                    fail_count++;
                end
                if (out_data.speed_value !== want.speed_value)
                begin
                    $error("speed_value: expected %0d, actual %0d",
                           want.speed_value, out_data.speed_value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        in_item_t  it;
        out_item_t typed_reading;
        bit        pressed;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        fail_count    = 0;
        items_sent    = 0;
        stall_cycles  = 0;
        hold_left     = 0;
        hold_request  = 1'b0;
        pressed       = 1'b0;
        src_idle_pct  = 27;
        sink_idle_pct = 83;
        clear_message();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
        begin
            it.data_byte              = DIRECTED_ROWS[i].data;
            it.last_byte              = DIRECTED_ROWS[i].last;
            typed_reading.power_value = DIRECTED_ROWS[i].power;
            typed_reading.speed_value = DIRECTED_ROWS[i].speed;
            send_item(it, DIRECTED_ROWS[i].typed, typed_reading);
        end

        for (int ph = 1; ph <= 3; ph++)
        begin
            src_idle_pct  = (ph == 1) ? 27 : (ph == 2) ? 83 : 0;
            sink_idle_pct = (ph == 1) ? 83 : (ph == 2) ? 27 : 0;
            while (items_sent < DIRECTED_N + ph * RANDOM_ITEMS / 3)
            begin
                // Stall the result side and feed fifteen one-byte messages, each of which
                // makes a reading, so that the input backs up.
                if (ph == 3 && !pressed)
                begin
                    pressed      = 1'b1;
                    hold_request = 1'b1;
                    repeat (15)
                    begin
                        it.data_byte = 8'($urandom_range(0, 255));
                        it.last_byte = 1'b1;
                        send_item(it, 1'b0, '0);
                    end
                end
                build_message();
                send_message();
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ bracketed_decimal_record_parser.f @@
src/bdrp_pkg.sv
src/bdrp_step.sv
src/bracketed_decimal_record_parser.sv
verif/bracketed_decimal_record_parser_tb.sv
